@@ sv/nofe_pkg.sv @@
// Shared constants, types and a helper function for the OOK frame encoder.
`default_nettype none

package nofe_pkg;

  // Frame layout constants.
  localparam int FRAME_BYTES_DEF = 17;
  localparam int SYNC_BYTES      = 3;
  localparam logic [7:0] SYNC_ONE  = 8'hFF;
  localparam logic [7:0] SYNC_ZERO = 8'h00;
  localparam logic [7:0] LEAD_BYTE = 8'h5D;

  // The 32-bit payload word plus one trailing 1 that produces the 1000 tail.
  localparam int WORD_BITS = 33;
  localparam int REM_W     = $clog2(WORD_BITS + 1);

  // Symbol pairs packed per output byte.
  localparam int PAIRS_PER_BYTE = 4;
  localparam logic [1:0] PAIR_MARK  = 2'b10;
  localparam logic [1:0] PAIR_SPACE = 2'b00;

  typedef struct packed {
    logic load;
    logic step;
  } pack_ctrl_t;

  typedef struct packed {
    logic drained;
  } pack_stat_t;

  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7 - i] = v[i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/nofe_ifs.sv @@
// Valid/ready channel interfaces for command items and frame bytes.
`default_nettype none

interface nofe_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] command_code;
  logic [7:0] pin_code;

  modport source (output valid, command_code, pin_code, input ready);
  modport sink (input valid, command_code, pin_code, output ready);
endinterface

interface nofe_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

`default_nettype wire

@@ sv/nofe_symbol_packer.sv @@
// Expands the payload word into pulse-distance symbols, eight symbols per step.
`default_nettype none

module nofe_symbol_packer (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire nofe_pkg::pack_ctrl_t               ctrl,
  input  wire logic [nofe_pkg::WORD_BITS-1:0]     word,
  output logic [7:0]                              sym_byte,
  output nofe_pkg::pack_stat_t                    stat
);

  logic [nofe_pkg::WORD_BITS-1:0] sreg;
  logic [nofe_pkg::WORD_BITS-1:0] sreg_next;
  logic [nofe_pkg::REM_W-1:0]     rem;
  logic [nofe_pkg::REM_W-1:0]     rem_next;
  logic                           pend;
  logic                           pend_next;

  // Every bit starts with a mark pair (10); a one bit adds a space pair (00),
  // held in pend so that it may spill into the next byte.
  always_comb begin
    logic [nofe_pkg::WORD_BITS-1:0] s;
    logic [nofe_pkg::REM_W-1:0]     r;
    logic                           p;
    logic [1:0]                     pair;
    s = sreg;
    r = rem;
    p = pend;
    sym_byte = '0;
    for (int i = 0; i < nofe_pkg::PAIRS_PER_BYTE; i++) begin
      if (p) begin
        pair = nofe_pkg::PAIR_SPACE;
        p    = 1'b0;
      end else if (r != '0) begin
        pair = nofe_pkg::PAIR_MARK;
        p    = s[nofe_pkg::WORD_BITS-1];
        s    = {s[nofe_pkg::WORD_BITS-2:0], 1'b0};
        r    = r - nofe_pkg::REM_W'(1);
      end else begin
        pair = nofe_pkg::PAIR_SPACE;
      end
      sym_byte[7 - 2*i -: 2] = pair;
    end
    sreg_next = s;
    rem_next  = r;
    pend_next = p;
  end

  assign stat.drained = (rem == '0) && !pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem  <= '0;
      pend <= 1'b0;
    end else if (ctrl.load) begin
      rem  <= nofe_pkg::REM_W'(nofe_pkg::WORD_BITS);
      pend <= 1'b0;
    end else if (ctrl.step) begin
      rem  <= rem_next;
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sreg <= word;
    end else if (ctrl.step) begin
      sreg <= sreg_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/nec_ook_frame_encoder_core.sv @@
// Pulse-distance remote frame encoder: one command item in, FRAME_BYTES bytes out.
//
// Usage:
//   The item channel takes a command byte and a PIN byte per transaction.
//   The frame channel returns FRAME_BYTES transactions per item, one byte
//   each, with the earliest symbol in the MSB; last_byte marks the final one.
//   Each frame is FF FF 00, then the symbols of 5D, the bit-reversed PIN,
//   the command and its complement (1 -> 1000, 0 -> 10), a 1000 tail and
//   zero padding.
//   Accepting an item sets active and clears idx; the frame's first byte then
//   moves into the output register. Throughput: one byte per cycle while the
//   receiver is ready; the symbol packer emits eight symbols per payload byte.
//   The next item is accepted in the cycle the last byte of the current
//   frame is loaded into the output register, so frames follow without gaps.
//   A stalled receiver freezes the frame in place; the output register holds
//   its byte and no item is accepted until the final byte is loaded into it.
//   Reset empties the output register and drops any frame in progress.
`default_nettype none

module nec_ook_frame_encoder_core #(
  parameter int FRAME_BYTES = nofe_pkg::FRAME_BYTES_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  nofe_item_if.sink  item,
  nofe_frame_if.source frame
);

  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(FRAME_BYTES - 1);
  localparam logic [IDX_W-1:0] SYNC_LAST = IDX_W'(nofe_pkg::SYNC_BYTES - 1);
  localparam logic [IDX_W-1:0] SYNC_END  = IDX_W'(nofe_pkg::SYNC_BYTES);

  logic                           active;
  logic [IDX_W-1:0]               idx;
  logic                           adv;
  logic                           is_last;
  logic                           accept;
  logic [7:0]                     byte_sel;
  logic [7:0]                     sym_byte;
  logic [nofe_pkg::WORD_BITS-1:0] load_word;
  nofe_pkg::pack_ctrl_t           pk_ctrl;
  nofe_pkg::pack_stat_t           pk_stat;

  assign adv        = active && (!frame.valid || frame.ready);
  assign is_last    = (idx == LAST_IDX);
  assign item.ready = !active || (adv && is_last);
  assign accept     = item.valid && item.ready;

  assign load_word = {nofe_pkg::LEAD_BYTE, nofe_pkg::reverse8(item.pin_code),
                      item.command_code, ~item.command_code, 1'b1};

  assign pk_ctrl.load = accept;
  assign pk_ctrl.step = adv && (idx >= SYNC_END);

  nofe_symbol_packer u_packer (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (pk_ctrl),
    .word     (load_word),
    .sym_byte (sym_byte),
    .stat     (pk_stat)
  );

  always_comb begin
    priority if (idx < SYNC_LAST) begin
      byte_sel = nofe_pkg::SYNC_ONE;
    end else if (idx == SYNC_LAST) begin
      byte_sel = nofe_pkg::SYNC_ZERO;
    end else begin
      byte_sel = sym_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      idx         <= '0;
      frame.valid <= 1'b0;
    end else begin
      if (accept) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (adv) begin
        if (is_last) begin
          active <= 1'b0;
        end
        idx <= idx + IDX_W'(1);
      end
      if (adv) begin
        frame.valid <= 1'b1;
      end else if (frame.ready) begin
        frame.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      frame.frame_byte <= byte_sel;
      frame.last_byte  <= is_last;
    end
  end

  // A new item only enters an idle encoder or one that is finishing its frame.
  a_accept_when_free: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!active || (adv && is_last)))
    else $error("item accepted while a frame is still in progress");

  a_accept_starts_frame: assert property (@(posedge clk) disable iff (rst)
    accept |=> (active && idx == '0))
    else $error("accepted item did not start a frame at byte zero");

  // Every symbol has been packed once the final byte is loaded, unless a new
  // item reloads the packer at that same edge.
  a_drained_at_last: assert property (@(posedge clk) disable iff (rst)
    (adv && is_last && !accept) |=> pk_stat.drained)
    else $error("symbols left over at the end of the frame");

  a_last_once: assert property (@(posedge clk) disable iff (rst)
    (adv && is_last && !accept) |=> !active)
    else $error("encoder stayed busy after the final byte");

endmodule

`default_nettype wire

@@ tb/tb_nec_ook_frame_encoder_core.sv @@
// Self-checking testbench for the pulse-distance remote frame encoder core.
`timescale 1ns / 100ps

module tb_nec_ook_frame_encoder_core;

  localparam int FRAME_BYTES = nofe_pkg::FRAME_BYTES_DEF;
  localparam int STREAM_BITS = 256;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_GAP     = 18;

  typedef struct {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_beat_t;

  logic clk = 1'b0;
  logic rst;

  nofe_item_if  item_ch ();
  nofe_frame_if frame_ch ();

  frame_beat_t pending_frame_bytes[$];
  int error_count = 0;
  int cycle_count = 0;
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;

  nec_ook_frame_encoder_core #(
    .FRAME_BYTES(FRAME_BYTES)
  ) uut (
    .clk  (clk),
    .rst  (rst),
    .item (item_ch),
    .frame(frame_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[cycle %0d] %s", cycle_count, msg);
    error_count++;
  endtask

  // Builds the symbol stream of one frame and queues its bytes in order.
  function automatic void encode_frame(input logic [7:0] cmd, input logic [7:0] pin);
    logic [STREAM_BITS-1:0] stream;
    logic [7:0]             pin_rev;
    logic [31:0]            word;
    frame_beat_t            beat;
    int                     pos;
    stream = '0;
    pos = 0;
    // Sync bytes FF FF 00: sixteen ones, then eight zeros.
    for (int i = 0; i < 16; i++) begin
      stream[STREAM_BITS-1-pos] = 1'b1;
      pos++;
    end
    pos += 8;
    for (int i = 0; i < 8; i++) begin
      pin_rev[i] = pin[7-i];
    end
    word = {nofe_pkg::LEAD_BYTE, pin_rev, cmd, ~cmd};
    // A one bit is a mark and three spaces, a zero bit is a mark and one space.
    for (int i = 31; i >= 0; i--) begin
      stream[STREAM_BITS-1-pos] = 1'b1;
      pos += word[i] ? 4 : 2;
    end
    stream[STREAM_BITS-1-pos] = 1'b1;
    pos += 4;
    for (int k = 0; k < FRAME_BYTES; k++) begin
      beat.frame_byte = stream[STREAM_BITS-1-8*k -: 8];
      beat.last_byte  = (k == FRAME_BYTES - 1);
      pending_frame_bytes.push_back(beat);
    end
  endfunction

  function automatic int draw_gap(input bit enabled);
    if (!enabled || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Presents one command item and returns at the edge where it is taken.
  task automatic send_command(input logic [7:0] cmd, input logic [7:0] pin);
    int gap;
    gap = draw_gap(sender_idles);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.command_code <= cmd;
    item_ch.pin_code     <= pin;
    do @(posedge clk); while (!item_ch.ready);
    encode_frame(cmd, pin);
  endtask

  task automatic drain_frames();
    item_ch.valid <= 1'b0;
    while (pending_frame_bytes.size() != 0) @(posedge clk);
    repeat (2 * FRAME_BYTES) @(posedge clk);
  endtask

  // Receiver: when receiver_idles is set, may hold ready low for a random stall before each transaction.
  initial begin
    int stall;
    frame_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap(receiver_idles);
      if (stall > 0) begin
        frame_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      frame_ch.ready <= 1'b1;
      do @(posedge clk); while (!frame_ch.valid);
    end
  end

  always @(posedge clk) begin
    frame_beat_t want;
    if (!rst && frame_ch.valid && frame_ch.ready) begin
      if (pending_frame_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected frame byte %02h", frame_ch.frame_byte));
      end else begin
        want = pending_frame_bytes.pop_front();
        if (frame_ch.frame_byte !== want.frame_byte) begin
          report_mismatch($sformatf("frame_byte: expected %02h, got %02h",
                                    want.frame_byte, frame_ch.frame_byte));
        end
        if (frame_ch.last_byte !== want.last_byte) begin
          report_mismatch($sformatf("last_byte: expected %0b, got %0b",
                                    want.last_byte, frame_ch.last_byte));
        end
      end
    end
  end

  task automatic test_field_extremes();
    send_command(8'h00, 8'h00);
    send_command(8'hFF, 8'hFF);
    send_command(8'h00, 8'hFF);
    send_command(8'hFF, 8'h00);
    send_command(8'h55, 8'hAA);
    send_command(8'hAA, 8'h55);
    drain_frames();
  endtask

  // Single set bits and nibble patterns show that the PIN goes out reversed and the command does not.
  task automatic test_bit_order();
    send_command(8'h01, 8'h01);
    send_command(8'h80, 8'h80);
    send_command(8'h0F, 8'hF0);
    send_command(8'hF0, 8'h0F);
    send_command(8'h01, 8'h80);
    send_command(8'h80, 8'h01);
    drain_frames();
  endtask

  // Each extra PIN one bit moves the tail by two symbols across byte boundaries.
  task automatic test_tail_split();
    logic [7:0] pin;
    pin = 8'h00;
    for (int i = 0; i <= 8; i++) begin
      send_command(8'h3C, pin);
      pin = {pin[6:0], 1'b1};
    end
    drain_frames();
  endtask

  task automatic test_back_to_back();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    for (int i = 0; i < 30; i++) begin
      send_command(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
    drain_frames();
  endtask

  task automatic test_random_frames();
    for (int blk = 0; blk < 19; blk++) begin
      sender_idles   = ($urandom_range(0, 3) != 0);
      receiver_idles = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 20; i++) begin
        send_command(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
    end
    drain_frames();
  endtask

  initial begin
    rst                  = 1'b1;
    item_ch.valid        = 1'b0;
    item_ch.command_code = 8'h00;
    item_ch.pin_code     = 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_bit_order();
    test_tail_split();
    test_back_to_back();
    test_random_frames();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/nofe_pkg.sv
sv/nofe_ifs.sv
sv/nofe_symbol_packer.sv
sv/nec_ook_frame_encoder_core.sv
tb/tb_nec_ook_frame_encoder_core.sv
